// ===== rtl/hed_pkg.sv =====
// hed_pkg: shared types, character codes, entity table and UTF-8 helpers
// for the HTML entity decoder. No dependencies.
package hed_pkg;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;

	localparam logic [20:0] MAX_CODE = 21'h1FFFFF;
	localparam int NUM_ENT = 13;

	// scanner modes
	typedef enum logic [2:0] {
		M_PLAIN, M_AMP, M_NAME, M_HASH, M_DEC, M_HEX
	} mode_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE, ST_HEAD, ST_EXTRA, ST_TAIL
	} ctl_state_t;

	// output phase: buffered text before, extra bytes, buffered text after
	typedef enum logic [1:0] {
		PH_HEAD, PH_EXTRA, PH_TAIL
	} phase_t;

	typedef struct packed {
		logic   accept;
		logic   issue;
		phase_t phase;
		logic   last;
	} hed_cmd_t;

	typedef struct packed {
		logic issue_ok;
	} hed_stat_t;

	// named entity table, names right-justified
	localparam logic [47:0] ENT_TEXT [NUM_ENT] = '{
		48'("quot"), 48'("amp"), 48'("apos"), 48'("lt"), 48'("gt"),
		48'("nbsp"), 48'("copy"), 48'("reg"), 48'("trade"),
		48'("hyphen"), 48'("dash"), 48'("ndash"), 48'("mdash")
	};
	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{
		3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd5,
		3'd6, 3'd4, 3'd5, 3'd5
	};
	localparam logic [20:0] ENT_CODE [NUM_ENT] = '{
		21'h22, 21'h26, 21'h27, 21'h3C, 21'h3E, 21'hA0, 21'hA9, 21'hAE,
		21'h2122, 21'h2010, 21'h2010, 21'h2013, 21'h2014
	};

	// character p of entity i (valid when p is below its length)
	function automatic logic [7:0] ent_char(input int i, input logic [2:0] p);
		logic [47:0] t;
		logic [2:0]  sh;
		sh = ENT_LEN[i] - 3'd1 - p;
		t  = ENT_TEXT[i] >> {sh, 3'b000};
		return t[7:0];
	endfunction

	// number of UTF-8 bytes for a code point
	function automatic logic [2:0] utf8_len(input logic [20:0] v);
		if (v <= 21'h7F)
			return 3'd1;
		else if (v <= 21'h7FF)
			return 3'd2;
		else if (v <= 21'hFFFF)
			return 3'd3;
		else
			return 3'd4;
	endfunction

	// byte j of the UTF-8 form of v, which is len bytes long
	function automatic logic [7:0] utf8_byte(input logic [20:0] v,
			input logic [2:0] len, input logic [1:0] j);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			3'd1: b = v[7:0];
			3'd2: begin
				if (j == 2'd0) b = {3'b110, v[10:6]};
				else           b = {2'b10, v[5:0]};
			end
			3'd3: begin
				case (j)
					2'd0:    b = {4'b1110, v[15:12]};
					2'd1:    b = {2'b10, v[11:6]};
					default: b = {2'b10, v[5:0]};
				endcase
			end
			default: begin
				case (j)
					2'd0:    b = {5'b11110, v[20:18]};
					2'd1:    b = {2'b10, v[17:12]};
					2'd2:    b = {2'b10, v[11:6]};
					default: b = {2'b10, v[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/hed_in_if.sv =====
// hed_in_if: input text channel, one byte per transaction.
// Depends on nothing.
interface hed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ===== rtl/hed_out_if.sv =====
// hed_out_if: result channel, one output byte per transaction.
// Depends on nothing.
interface hed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_decoded;
	logic       last_of_run;

	modport source (output valid, output out_byte, output is_decoded,
		output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input is_decoded,
		input last_of_run, output ready);
endinterface

// ===== rtl/hed_ctrl.sv =====
// hed_ctrl: controller of the entity decoder; sequences the output bytes
// of one transaction in three phases. Depends on hed_pkg.
module hed_ctrl #(
	parameter int CNT_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hed_pkg::hed_stat_t  stat,
	input  logic [CNT_W-1:0]    f_cnt,
	input  logic [2:0]          k_cnt,
	input  logic [CNT_W-1:0]    g_cnt,
	output hed_pkg::hed_cmd_t   cmd,
	output logic [CNT_W-1:0]    idx
);
	import hed_pkg::*;

	ctl_state_t       state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cnt;
	logic             later_zero;
	ctl_state_t       nxt;

	// state and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.phase  = PH_HEAD;
		cnt        = f_cnt;
		later_zero = (k_cnt == 3'd0) && (g_cnt == '0);
		nxt        = ST_EXTRA;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_HEAD;
					idx_d      = '0;
				end
			end
			ST_HEAD: begin
				cmd.phase = PH_HEAD;
			end
			ST_EXTRA: begin
				cmd.phase  = PH_EXTRA;
				cnt        = CNT_W'(k_cnt);
				later_zero = (g_cnt == '0);
				nxt        = ST_TAIL;
			end
			ST_TAIL: begin
				cmd.phase  = PH_TAIL;
				cnt        = g_cnt;
				later_zero = 1'b1;
				nxt        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// byte issue within a phase
		if (state_q != ST_IDLE) begin
			if (idx_q == cnt) begin
				state_d = nxt;
				idx_d   = '0;
			end else if (stat.issue_ok) begin
				cmd.issue = 1'b1;
				cmd.last  = (idx_q + 1'b1 == cnt) && later_zero;
				if (idx_q + 1'b1 == cnt) begin
					state_d = nxt;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
		end
	end

	assign idx = idx_q;

endmodule

// ===== rtl/hed_dp.sv =====
// hed_dp: datapath of the entity decoder: scanner state, pending buffer,
// value accumulator, name matcher and the output stages. Depends on hed_pkg.
module hed_dp #(
	parameter int MAX_NAME = 16,
	parameter int PEND     = 19,
	parameter int CNT_W    = 5,
	parameter int IDX_W    = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hed_pkg::hed_cmd_t   cmd,
	input  logic [CNT_W-1:0]    idx,
	input  logic [7:0]          in_byte,
	input  logic                end_of_text,
	output hed_pkg::hed_stat_t  stat,
	output logic [CNT_W-1:0]    f_cnt,
	output logic [2:0]          k_cnt,
	output logic [CNT_W-1:0]    g_cnt,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                is_decoded,
	output logic                last_of_run
);
	import hed_pkg::*;

	// scanner state
	mode_t            mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [20:0]      code_q;
	logic             ovf_q;
	logic [NUM_ENT-1:0] match_q;
	logic [7:0]       pend_mem [PEND];

	// per transaction plan
	logic [7:0]       raw_q;
	logic [CNT_W-1:0] f_q, g_q;
	logic [2:0]       k_q;
	logic             utf_q;
	logic [20:0]      val_q;

	// next values
	mode_t            n_mode;
	logic [CNT_W-1:0] n_cnt, f_d, g_d;
	logic [2:0]       k_d;
	logic [20:0]      n_code, val_d;
	logic             n_ovf, utf_d, push, set_match, upd_match;
	logic [7:0]       raw_d;

	// character classes and digit value
	logic             is_dig, is_hex, is_aln;
	logic [3:0]       dv;
	logic [24:0]      nv;
	logic             base16, add_dig;
	logic [CNT_W-1:0] pos;
	logic [NUM_ENT-1:0] nm;
	logic             found;
	logic [20:0]      found_code;

	always_comb begin
		is_dig = (in_byte >= "0") && (in_byte <= "9");
		is_hex = is_dig || ((in_byte >= "a") && (in_byte <= "f")) ||
			((in_byte >= "A") && (in_byte <= "F"));
		is_aln = is_dig || ((in_byte >= "a") && (in_byte <= "z")) ||
			((in_byte >= "A") && (in_byte <= "Z"));
		if (is_dig)
			dv = 4'(in_byte - "0");
		else if (in_byte >= "a")
			dv = 4'(in_byte - "a" + 8'd10);
		else
			dv = 4'(in_byte - "A" + 8'd10);
	end

	// name matcher: prefix match per table entry, exact match on ';'
	assign pos = cnt_q - 1'b1;
	always_comb begin
		found      = 1'b0;
		found_code = '0;
		for (int i = 0; i < NUM_ENT; i++) begin
			nm[i] = match_q[i] && (pos < CNT_W'(ENT_LEN[i])) &&
				(ent_char(i, pos[2:0]) == in_byte);
			if (match_q[i] && (pos == CNT_W'(ENT_LEN[i]))) begin
				found      = 1'b1;
				found_code = found_code | ENT_CODE[i];
			end
		end
	end

	// digit accumulation
	assign base16 = (mode_q == M_HEX);
	assign nv = base16 ? {code_q, 4'b0000} + 25'(dv)
		: {1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0} + 25'(dv);

	// decision for one input byte
	always_comb begin
		n_mode    = mode_q;
		n_cnt     = cnt_q;
		n_code    = code_q;
		n_ovf     = ovf_q;
		push      = 1'b0;
		set_match = 1'b0;
		upd_match = 1'b0;
		f_d       = '0;
		k_d       = 3'd0;
		raw_d     = in_byte;
		utf_d     = 1'b0;
		val_d     = '0;
		add_dig   = 1'b0;
		case (mode_q)
			M_AMP, M_NAME: begin
				if (mode_q == M_AMP && in_byte == CH_HASH) begin
					push   = 1'b1;
					n_mode = M_HASH;
					n_code = '0;
					n_ovf  = 1'b0;
				end else if (is_aln) begin
					if (cnt_q >= CNT_W'(MAX_NAME + 1)) begin
						f_d = cnt_q; k_d = 3'd1;
						n_cnt = '0; n_mode = M_PLAIN;
					end else begin
						push = 1'b1; upd_match = 1'b1; n_mode = M_NAME;
					end
				end else if (in_byte == CH_SEMI) begin
					n_cnt = '0; n_mode = M_PLAIN;
					if (found) begin
						utf_d = 1'b1; val_d = found_code;
						k_d = utf8_len(found_code);
					end else begin
						f_d = cnt_q; k_d = 3'd1;
					end
				end else begin
					f_d = cnt_q;
					if (in_byte == CH_AMP) begin
						n_cnt = CNT_W'(1); n_mode = M_AMP; set_match = 1'b1;
					end else begin
						k_d = 3'd1; n_cnt = '0; n_mode = M_PLAIN;
					end
				end
			end
			M_HASH, M_DEC, M_HEX: begin
				if (mode_q == M_HASH && in_byte == CH_X) begin
					push   = 1'b1;
					n_mode = M_HEX;
				end else if ((mode_q != M_HEX && is_dig) ||
						(mode_q == M_HEX && is_hex)) begin
					if (cnt_q >= CNT_W'(MAX_NAME + 2) + CNT_W'(base16)) begin
						f_d = cnt_q; k_d = 3'd1;
						n_cnt = '0; n_mode = M_PLAIN;
					end else begin
						push = 1'b1; add_dig = 1'b1;
						n_mode = base16 ? M_HEX : M_DEC;
					end
				end else if (in_byte == CH_SEMI) begin
					n_cnt = '0; n_mode = M_PLAIN;
					if (!ovf_q && code_q != '0) begin
						utf_d = 1'b1; val_d = code_q;
						k_d = utf8_len(code_q);
					end else begin
						f_d = cnt_q; k_d = 3'd1;
					end
				end else begin
					f_d = cnt_q;
					if (in_byte == CH_AMP) begin
						n_cnt = CNT_W'(1); n_mode = M_AMP; set_match = 1'b1;
					end else begin
						k_d = 3'd1; n_cnt = '0; n_mode = M_PLAIN;
					end
				end
			end
			default: begin
				n_mode = M_PLAIN;
				if (in_byte == CH_AMP) begin
					n_cnt = CNT_W'(1); n_mode = M_AMP; set_match = 1'b1;
				end else begin
					k_d = 3'd1;
				end
			end
		endcase
		if (push)
			n_cnt = cnt_q + 1'b1;
		if (add_dig && !ovf_q) begin
			if (nv > 25'(MAX_CODE))
				n_ovf = 1'b1;
			else
				n_code = nv[20:0];
		end
		// end of text flushes whatever is left
		g_d = '0;
		if (end_of_text) begin
			g_d    = n_cnt;
			n_cnt  = '0;
			n_mode = M_PLAIN;
		end
	end

	// scanner and plan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_PLAIN;
			cnt_q   <= '0;
			code_q  <= '0;
			ovf_q   <= 1'b0;
			match_q <= '0;
			f_q     <= '0;
			k_q     <= 3'd0;
			g_q     <= '0;
		end else if (cmd.accept) begin
			mode_q <= n_mode;
			cnt_q  <= n_cnt;
			code_q <= n_code;
			ovf_q  <= n_ovf;
			f_q    <= f_d;
			k_q    <= k_d;
			g_q    <= g_d;
			if (set_match)
				match_q <= '1;
			else if (upd_match)
				match_q <= nm;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			raw_q <= raw_d;
			utf_q <= utf_d;
			val_q <= val_d;
		end
	end

	assign f_cnt = f_q;
	assign k_cnt = k_q;
	assign g_cnt = g_q;

	// output stage s1 and output register
	logic             valid_s1, amp_s1, mem_s1, dec_s1, last_s1;
	logic [7:0]       rd_s1, ext_s1;
	logic             out_valid_q, dec_q, last_q;
	logic [7:0]       byte_q;
	logic             move;

	assign move = valid_s1 && (!out_valid_q || out_ready);
	assign stat.issue_ok = !valid_s1 || move;

	// pending buffer; entry zero is always '&' and is never stored
	always_ff @(posedge clk) begin
		if (cmd.accept && push)
			pend_mem[cnt_q[IDX_W-1:0]] <= in_byte;
		if (cmd.issue)
			rd_s1 <= pend_mem[idx[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			mem_s1  <= (cmd.phase != PH_EXTRA);
			amp_s1  <= (idx == '0);
			dec_s1  <= (cmd.phase == PH_EXTRA) && utf_q;
			last_s1 <= cmd.last;
			ext_s1  <= utf_q ? utf8_byte(val_q, k_q, idx[1:0]) : raw_q;
		end
		if (move) begin
			byte_q <= mem_s1 ? (amp_s1 ? CH_AMP : rd_s1) : ext_s1;
			dec_q  <= dec_s1;
			last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.issue)
				valid_s1 <= 1'b1;
			else if (move)
				valid_s1 <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign is_decoded  = dec_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/html_entity_decoder.sv =====
// HTML entity decoder with UTF-8 output. One text byte is taken per input
// transaction when the block is idle; its result bytes then leave one per
// cycle within an output phase, unless the output stalls, through a read
// stage and an output register. Each of the three output phases (buffered
// text flushed, plain or UTF-8 bytes, end-of-text flush) passes through its
// controller state even when it is empty, and no new byte is taken before
// all result bytes of the last one are issued. The sequencing controller
// and the single-port pending buffer enforce this one-byte-at-a-time flow.
// Depends on hed_pkg, hed_in_if, hed_out_if, hed_ctrl, hed_dp.
module html_entity_decoder #(
	parameter int MAX_NAME = 16
) (
	input logic       clk,
	input logic       arst_n,
	hed_in_if.sink    text,
	hed_out_if.source result
);
	import hed_pkg::*;

	localparam int PEND  = MAX_NAME + 3;
	localparam int CNT_W = $clog2(PEND + 1);
	localparam int IDX_W = $clog2(PEND);

	hed_cmd_t         cmd;
	hed_stat_t        stat;
	logic [CNT_W-1:0] idx, f_cnt, g_cnt;
	logic [2:0]       k_cnt;

	hed_ctrl #(.CNT_W(CNT_W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.stat     (stat),
		.f_cnt    (f_cnt),
		.k_cnt    (k_cnt),
		.g_cnt    (g_cnt),
		.cmd      (cmd),
		.idx      (idx)
	);

	hed_dp #(
		.MAX_NAME (MAX_NAME),
		.PEND     (PEND),
		.CNT_W    (CNT_W),
		.IDX_W    (IDX_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.in_byte     (text.in_byte),
		.end_of_text (text.end_of_text),
		.stat        (stat),
		.f_cnt       (f_cnt),
		.k_cnt       (k_cnt),
		.g_cnt       (g_cnt),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_byte    (result.out_byte),
		.is_decoded  (result.is_decoded),
		.last_of_run (result.last_of_run)
	);

	// an accepted byte is worked off before the next one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready) |=> !text.ready)
		else $error("input accepted while previous one in progress");

	// a byte is only issued when the read stage can take it
	a_issue_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> stat.issue_ok)
		else $error("read stage overrun");

	// acceptance and byte issue never coincide
	a_accept_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !cmd.issue)
		else $error("issue during accept");

endmodule
